/* src/pdlr_pkg.sv */
// ----------------------------------------------------------------------------
// pdlr_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the PCM downmix and linear resampler.
// ----------------------------------------------------------------------------
package pdlr_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CNT_W      = 4;
  localparam int STEP_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int RESULT_CAP = 16;
  localparam int CAP_W      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESAMPLE_STEP = 2'd1;

  localparam logic [CNT_W-1:0]  CNT_RESET  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_RESET = 20'h10000;

  // controller -> datapath
  typedef struct packed {
    logic acc;        // add the accepted sample into the frame sum
    logic frame_end;  // frame completes: load divider, clear frame state
    logic div_step;   // one restoring-division step
    logic mono_ld;    // take the quotient as the new mono sample
    logic mul;        // register (mono - previous) * phase
    logic emit;       // write one result into the output register
    logic skip;       // no result for this mono sample
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic frame_done;
    logic div_last;
    logic hist_valid;
    logic phase_lt_one;
    logic out_free;
    logic emit_last;
  } dp_status_t;

endpackage

/* src/pcm_downmix_linear_resampler.sv */
// ----------------------------------------------------------------------------
// pcm_downmix_linear_resampler
// Averages interleaved PCM channels to mono and resamples the mono stream
// by linear interpolation.
// ----------------------------------------------------------------------------
// Mid-frame sample: accepted straight into the frame sum.
// Frame-completing sample: runs the serial divider, forms the mono sample,
//   then for each result multiplies, then writes the output register, and
//   waits there on output stalls. One item in flight; the output register
//   holds a result while the next input is taken. Reset is asynchronous,
//   active low; it clears all state but the divider and data registers.
// ----------------------------------------------------------------------------
module pcm_downmix_linear_resampler
  import pdlr_pkg::*;
#(
  parameter int MAX_CHANNELS    = 8,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] channel_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] out_sample_o,
  output logic                       last_of_run_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  pdlr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pdlr_datapath #(
    .MAX_CHANNELS    (MAX_CHANNELS),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .channel_sample_i (channel_sample_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .out_sample_o     (out_sample_o),
    .last_of_run_o    (last_of_run_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule

/* src/pdlr_ctrl.sv */
// ----------------------------------------------------------------------------
// pdlr_ctrl
// Sequencer: accepts samples, runs the divider, then walks the phase and
// issues one result per ST_CHK/ST_EMIT pair, held in ST_EMIT on output stalls.
// ----------------------------------------------------------------------------
module pdlr_ctrl
  import pdlr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MONO = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (status_i.frame_done) begin
            cmd_o.frame_end = 1'b1;
            state_d         = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_MONO;
        end
      end
      ST_MONO: begin
        cmd_o.mono_ld = 1'b1;
        state_d = status_i.hist_valid ? ST_CHK : ST_IDLE;
      end
      ST_CHK: begin
        if (status_i.phase_lt_one) begin
          cmd_o.mul = 1'b1;
          state_d   = ST_EMIT;
        end else begin
          cmd_o.skip = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_EMIT: begin
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = status_i.emit_last ? ST_IDLE : ST_CHK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/pdlr_datapath.sv */
// ----------------------------------------------------------------------------
// pdlr_datapath
// Configuration registers, frame accumulator, bit-serial divider,
// interpolation multiplier, phase accumulator and output register.
// ----------------------------------------------------------------------------
module pdlr_datapath
  import pdlr_pkg::*;
#(
  parameter int MAX_CHANNELS    = 8,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic signed [SAMPLE_W-1:0]  channel_sample_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic signed [SAMPLE_W-1:0]  out_sample_o,
  output logic                        last_of_run_o,
  input  dp_cmd_t                     cmd_i,
  output dp_status_t                  status_o
);

  localparam int F      = PHASE_FRAC_BITS;
  localparam int SW     = SAMPLE_W + $clog2(MAX_CHANNELS);
  localparam int IW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int DCW    = $clog2(SW);
  localparam int PW     = ((F > STEP_W) ? F : STEP_W) + 1;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + F + 1;

  localparam logic [PW-1:0] PHASE_ONE = PW'(1) << F;
  localparam logic [PW-1:0] STEP_MIN  = PHASE_ONE >> 4;

  // configuration
  logic [CNT_W-1:0]  cnt_q;
  logic [STEP_W-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= CNT_RESET;
      step_q <= STEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CHANNEL_COUNT: cnt_q  <= cfg_data_i[CNT_W-1:0];
        CFG_RESAMPLE_STEP: step_q <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] cnt_eff;
  logic [PW-1:0]    step_eff;

  always_comb begin
    cnt_eff = cnt_q;
    if (cnt_q == '0) begin
      cnt_eff = CNT_W'(1);
    end else if ({1'b0, cnt_q} > (CNT_W+1)'(MAX_CHANNELS)) begin
      cnt_eff = CNT_W'(MAX_CHANNELS);
    end
    step_eff = {{(PW-STEP_W){1'b0}}, step_q};
    if (step_eff < STEP_MIN) begin
      step_eff = STEP_MIN;
    end
  end

  // frame accumulation
  logic [IW-1:0]        idx_q;
  logic signed [SW-1:0] sum_q;
  logic signed [SW-1:0] sum_total;

  assign sum_total = sum_q + SW'(channel_sample_i);
  assign status_o.frame_done = (6'(idx_q) + 6'd1) >= 6'(cnt_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sum_q <= '0;
    end else if (cmd_i.acc) begin
      if (cmd_i.frame_end) begin
        idx_q <= '0;
        sum_q <= '0;
      end else begin
        idx_q <= idx_q + IW'(1);
        sum_q <= sum_total;
      end
    end
  end

  // restoring divider on the magnitude, one quotient bit per cycle
  logic [SW-1:0]    quo_q;
  logic [CNT_W-1:0] rem_q;
  logic [CNT_W-1:0] dvs_q;
  logic             neg_q;
  logic [DCW-1:0]   dcnt_q;
  logic [CNT_W:0]   rem_sh;
  logic             rem_ge;

  assign rem_sh = {rem_q, quo_q[SW-1]};
  assign rem_ge = rem_sh >= {1'b0, dvs_q};
  assign status_o.div_last = dcnt_q == DCW'(SW-1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.frame_end) begin
      neg_q  <= sum_total[SW-1];
      quo_q  <= sum_total[SW-1] ? SW'(-sum_total) : SW'(sum_total);
      rem_q  <= '0;
      dvs_q  <= cnt_eff;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? CNT_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[CNT_W-1:0];
      quo_q  <= {quo_q[SW-2:0], rem_ge};
      dcnt_q <= dcnt_q + DCW'(1);
    end
  end

  // signed quotient, truncated toward zero, saturated to 16 bits
  logic signed [SW:0]         quo_s;
  logic signed [SAMPLE_W-1:0] mono_new;

  always_comb begin
    quo_s = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    if (quo_s > (SW+1)'(32767)) begin
      mono_new = 16'sh7fff;
    end else if (quo_s < -(SW+1)'(32768)) begin
      mono_new = 16'sh8000;
    end else begin
      mono_new = quo_s[SAMPLE_W-1:0];
    end
  end

  // interpolation
  logic signed [SAMPLE_W-1:0] mono_q;
  logic signed [SAMPLE_W-1:0] prev_q;
  logic                       hist_valid_q;
  logic [PW-1:0]              phase_q;
  logic [CAP_W-1:0]           rcnt_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [DIFF_W:0]     interp;
  logic [PW-1:0]              phase_add;

  assign diff      = DIFF_W'(mono_q) - DIFF_W'(prev_q);
  assign interp    = (DIFF_W+1)'(prev_q) + (DIFF_W+1)'(prod_q >>> F);
  assign phase_add = phase_q + step_eff;

  assign status_o.hist_valid   = hist_valid_q;
  assign status_o.phase_lt_one = phase_q < PHASE_ONE;
  assign status_o.emit_last    = (phase_add >= PHASE_ONE) ||
                                 (rcnt_q == CAP_W'(RESULT_CAP-1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= diff * $signed({1'b0, phase_q[F-1:0]});
    end
    if (cmd_i.mono_ld) begin
      mono_q <= mono_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= '0;
      hist_valid_q <= 1'b0;
      phase_q      <= '0;
      rcnt_q       <= '0;
    end else begin
      if (cmd_i.mono_ld && !hist_valid_q) begin
        prev_q       <= mono_new;
        hist_valid_q <= 1'b1;
      end
      if (cmd_i.skip) begin
        phase_q <= phase_q - PHASE_ONE;
        prev_q  <= mono_q;
      end
      if (cmd_i.emit) begin
        if (status_o.emit_last) begin
          // drop one sample period off the phase (or clear it at the result cap) and advance the history
          phase_q <= (phase_add >= PHASE_ONE) ? phase_add - PHASE_ONE : '0;
          prev_q  <= mono_q;
          rcnt_q  <= '0;
        end else begin
          phase_q <= phase_add;
          rcnt_q  <= rcnt_q + CAP_W'(1);
        end
      end
    end
  end

  // output register
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                       out_last_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_sample_q <= interp[SAMPLE_W-1:0];
      out_last_q   <= status_o.emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_sample_o  = out_sample_q;
  assign last_of_run_o = out_last_q;

endmodule
